// File: rtl/igvt_pkg.sv
// Shared widths, register indexes and root control type for the inverse Gaussian transform.
`default_nettype none
package igvt_pkg;

  localparam int unsigned MuW     = 24;
  localparam int unsigned LamW    = 24;
  localparam int unsigned NuW     = 16;
  localparam int unsigned ZW      = 16;
  localparam int unsigned VarW    = 32;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 24;

  localparam int unsigned AW    = 54;   // A = M * n^2
  localparam int unsigned NW    = 57;   // N = A + 2B + S
  localparam int unsigned SW    = 56;   // floor(sqrt(A*(A+4B)))
  localparam int unsigned RadW  = 112;  // A*(A+4B)
  localparam int unsigned DivNW = 81;   // numerator width of both divisions (M*N < 2^81)
  localparam int unsigned DivDW = 57;   // divisor width
  localparam int unsigned QW    = 33;   // enough quotient bits to detect overflow

  typedef enum logic [CfgIdxW-1:0] {
    REG_MEAN_MU      = 1'b0,
    REG_SHAPE_LAMBDA = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic             small_root;
    logic [MuW-1:0]   mu;
    logic [LamW-1:0]  lam;
    logic [NW-1:0]    n;
  } root_ctl_t;

endpackage
`default_nettype wire

// File: rtl/igvt_sqrt.sv
// Pipelined restoring square root, one result bit per stage.
`default_nettype none
module igvt_sqrt #(
  parameter int unsigned RadW = igvt_pkg::RadW,
  parameter int unsigned SW   = igvt_pkg::SW,
  parameter int unsigned TagW = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire logic [RadW-1:0] rad_i,
  input  wire logic [TagW-1:0] tag_i,
  output logic                 valid_o,
  output logic [SW-1:0]        root_o,
  output logic [TagW-1:0]      tag_o
);

  // rem holds rad - root^2; test (4*rem + next two bits) against 4*root+1
  logic [SW:0]     valid_q;
  logic [RadW-1:0] rad_q  [SW+1];
  logic [SW-1:0]   root_q [SW+1];
  logic [SW+1:0]   rem_q  [SW+1];
  logic [TagW-1:0] tag_q  [SW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[SW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q[0]  <= rad_i;
    root_q[0] <= '0;
    rem_q[0]  <= '0;
    tag_q[0]  <= tag_i;
  end

  for (genvar g = 0; g < SW; g++) begin : g_step
    logic [SW+3:0] trial;
    logic [SW+3:0] sub;
    assign trial = {rem_q[g], rad_q[g][RadW-1-2*g -: 2]};
    assign sub   = {2'b00, root_q[g], 2'b01};
    always_ff @(posedge clk_i) begin
      rad_q[g+1] <= rad_q[g];
      tag_q[g+1] <= tag_q[g];
      if (trial >= sub) begin
        rem_q[g+1]  <= (SW+2)'(trial - sub);
        root_q[g+1] <= {root_q[g][SW-2:0], 1'b1};
      end else begin
        rem_q[g+1]  <= (SW+2)'(trial);
        root_q[g+1] <= {root_q[g][SW-2:0], 1'b0};
      end
    end
  end

  assign valid_o = valid_q[SW];
  assign root_o  = root_q[SW];
  assign tag_o   = tag_q[SW];

endmodule
`default_nettype wire

// File: rtl/igvt_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module igvt_div #(
  parameter int unsigned NumW = igvt_pkg::DivNW,
  parameter int unsigned DenW = igvt_pkg::DivDW,
  parameter int unsigned QW   = igvt_pkg::QW,
  parameter int unsigned TagW = 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  input  wire logic [TagW-1:0] tag_i,
  output logic                 valid_o,
  output logic [QW-1:0]        quot_o,
  output logic                 ovf_o,
  output logic [TagW-1:0]      tag_o
);

  // quotient bits above QW are folded into a sticky overflow flag at entry
  localparam int unsigned RemW = DenW + 1;

  logic [QW:0]      valid_q;
  logic [NumW-1:0]  num_q [QW+1];
  logic [DenW-1:0]  den_q [QW+1];
  logic [RemW-1:0]  rem_q [QW+1];
  logic [QW-1:0]    quot_q[QW+1];
  logic             ovf_q [QW+1];
  logic [TagW-1:0]  tag_q [QW+1];

  logic [NumW-QW-1:0] hi_part;
  assign hi_part = num_i[NumW-1:QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[QW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    num_q[0]  <= num_i;
    den_q[0]  <= den_i;
    quot_q[0] <= '0;
    tag_q[0]  <= tag_i;
    // high part must stay below the divisor for a QW-bit quotient
    if ({{(RemW+QW-NumW){1'b0}}, hi_part} >= {1'b0, den_i}) begin
      ovf_q[0] <= 1'b1;
      rem_q[0] <= '0;
    end else begin
      ovf_q[0] <= 1'b0;
      rem_q[0] <= RemW'(hi_part);
    end
  end

  for (genvar g = 0; g < QW; g++) begin : g_step
    logic [RemW:0] trial;
    assign trial = {rem_q[g], num_q[g][QW-1-g]};
    always_ff @(posedge clk_i) begin
      num_q[g+1] <= num_q[g];
      den_q[g+1] <= den_q[g];
      ovf_q[g+1] <= ovf_q[g];
      tag_q[g+1] <= tag_q[g];
      if (trial >= {2'b00, den_q[g]}) begin
        rem_q[g+1]  <= RemW'(trial - {2'b00, den_q[g]});
        quot_q[g+1] <= {quot_q[g][QW-2:0], 1'b1};
      end else begin
        rem_q[g+1]  <= RemW'(trial);
        quot_q[g+1] <= {quot_q[g][QW-2:0], 1'b0};
      end
    end
  end

  assign valid_o = valid_q[QW];
  assign quot_o  = quot_q[QW];
  assign ovf_o   = ovf_q[QW];
  assign tag_o   = tag_q[QW];

endmodule
`default_nettype wire

// File: rtl/inverse_gaussian_variate_transform_unit.sv
// Top level: inverse Gaussian variate pipeline (front end, square root, divide).
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------
//  config   | cfg_we_i, cfg_idx_i, cfg_data_i         | write when cfg_we_i
//  input    | normal_sample_i, uniform_sample_i       | start_i && !busy_o
//  result   | variate_o, saturated_o                  | done_o, one cycle
//
// One word enters per cycle; busy_o is never high. done_o rises after the
// front end, the bit-per-stage square root and divider, and the output register.
// Reset clears the valid bits and sets both registers to 1.0. The
// receiver cannot stall, so the pipeline never holds.
`default_nettype none
module inverse_gaussian_variate_transform_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [igvt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [igvt_pkg::CfgW-1:0]     cfg_data_i,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic signed [igvt_pkg::NuW-1:0] normal_sample_i,
  input  wire logic [igvt_pkg::ZW-1:0]       uniform_sample_i,
  output logic                               done_o,
  output logic [igvt_pkg::VarW-1:0]          variate_o,
  output logic                               saturated_o
);

  localparam int unsigned MuW  = igvt_pkg::MuW;
  localparam int unsigned LamW = igvt_pkg::LamW;
  localparam int unsigned AW   = igvt_pkg::AW;
  localparam int unsigned NW   = igvt_pkg::NW;
  localparam int unsigned SW   = igvt_pkg::SW;
  localparam int unsigned RadW = igvt_pkg::RadW;
  localparam int unsigned DNW  = igvt_pkg::DivNW;
  localparam int unsigned DDW  = igvt_pkg::DivDW;
  localparam int unsigned QW   = igvt_pkg::QW;
  localparam int unsigned BW   = LamW + 24;       // B = L * 2^24
  localparam int unsigned TagW = 1 + MuW + LamW + AW + 16;

  logic [MuW-1:0]  mu_q;
  logic [LamW-1:0] lam_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_q  <= MuW'(65536);
      lam_q <= LamW'(65536);
    end else if (cfg_we_i) begin
      unique case (igvt_pkg::cfg_reg_e'(cfg_idx_i))
        igvt_pkg::REG_MEAN_MU:      mu_q  <= cfg_data_i;
        igvt_pkg::REG_SHAPE_LAMBDA: lam_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // stage 1: magnitude squared, register operands
  logic            s1_v_q;
  logic [31:0]     s1_sq_q;
  logic [MuW-1:0]  s1_mu_q;
  logic [LamW-1:0] s1_lam_q;
  logic [15:0]     s1_z_q;
  logic [15:0]     mag;

  assign mag = normal_sample_i[15] ? 16'(-normal_sample_i) : normal_sample_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_sq_q  <= 32'(mag) * 32'(mag);
    s1_mu_q  <= mu_q;
    s1_lam_q <= (lam_q == '0) ? LamW'(1) : lam_q;
    s1_z_q   <= uniform_sample_i;
  end

  // stage 2: A = M * n^2
  logic            s2_v_q;
  logic [AW-1:0]   s2_a_q;
  logic [MuW-1:0]  s2_mu_q;
  logic [LamW-1:0] s2_lam_q;
  logic [15:0]     s2_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_a_q   <= AW'(AW'(s1_mu_q) * AW'(s1_sq_q[30:0]));
    s2_mu_q  <= s1_mu_q;
    s2_lam_q <= s1_lam_q;
    s2_z_q   <= s1_z_q;
  end

  // stage 3: A + 4B
  logic            s3_v_q;
  logic [AW-1:0]   s3_a_q;
  logic [AW:0]     s3_a4b_q;
  logic [MuW-1:0]  s3_mu_q;
  logic [LamW-1:0] s3_lam_q;
  logic [15:0]     s3_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_a_q   <= s2_a_q;
    s3_a4b_q <= (AW+1)'(s2_a_q) + (AW+1)'({s2_lam_q, 26'b0});
    s3_mu_q  <= s2_mu_q;
    s3_lam_q <= s2_lam_q;
    s3_z_q   <= s2_z_q;
  end

  // stages 4..6: radicand A*(A+4B), cut into 27-bit partial products
  localparam int unsigned PH = 27;
  logic            s4_v_q;
  logic [2*PH:0]   pp_q [4];
  logic [TagW-1:0] s4_tag_q;
  logic [AW-1:0]   a_lo;

  logic [PH-1:0] xa_lo, xa_hi, xb_lo;
  logic [PH:0]   xb_hi;
  assign xa_lo = s3_a_q[PH-1:0];
  assign xa_hi = s3_a_q[AW-1:PH];
  assign xb_lo = s3_a4b_q[PH-1:0];
  assign xb_hi = s3_a4b_q[AW:PH];
  assign a_lo  = s3_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pp_q[0]  <= (2*PH+1)'(xa_lo) * (2*PH+1)'(xb_lo);
    pp_q[1]  <= (2*PH+1)'(xa_lo) * (2*PH+1)'(xb_hi);
    pp_q[2]  <= (2*PH+1)'(xa_hi) * (2*PH+1)'(xb_lo);
    pp_q[3]  <= (2*PH+1)'(xa_hi) * (2*PH+1)'(xb_hi);
    s4_tag_q <= {1'b0, s3_mu_q, s3_lam_q, a_lo, s3_z_q};
  end

  logic            s5_v_q;
  logic [RadW-1:0] s5_mid_q;
  logic [RadW-1:0] s5_ends_q;
  logic [TagW-1:0] s5_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else begin
      s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_mid_q  <= (RadW'(pp_q[1]) + RadW'(pp_q[2])) << PH;
    s5_ends_q <= (RadW'(pp_q[3]) << (2*PH)) | RadW'(pp_q[0]);
    s5_tag_q  <= s4_tag_q;
  end

  logic            s6_v_q;
  logic [RadW-1:0] s6_rad_q;
  logic [TagW-1:0] s6_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_v_q <= 1'b0;
    end else begin
      s6_v_q <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s6_rad_q <= s5_mid_q + s5_ends_q;
    s6_tag_q <= s5_tag_q;
  end

  logic            sq_v;
  logic [SW-1:0]   sq_root;
  logic [TagW-1:0] sq_tag;

  igvt_sqrt #(.RadW(RadW), .SW(SW), .TagW(TagW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s6_v_q),
    .rad_i   (s6_rad_q),
    .tag_i   (s6_tag_q),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .tag_o   (sq_tag)
  );

  logic [MuW-1:0]  t_mu;
  logic [LamW-1:0] t_lam;
  logic [AW-1:0]   t_a;
  logic [15:0]     t_z;
  assign t_mu  = sq_tag[TagW-2 -: MuW];
  assign t_lam = sq_tag[TagW-2-MuW -: LamW];
  assign t_a   = sq_tag[16 +: AW];
  assign t_z   = sq_tag[15:0];

  // stage 7: N = A + 2B + S
  logic            s7_v_q;
  logic [NW-1:0]   s7_n_q;
  logic [MuW-1:0]  s7_mu_q;
  logic [LamW-1:0] s7_lam_q;
  logic [15:0]     s7_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_v_q <= 1'b0;
    end else begin
      s7_v_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    s7_n_q   <= NW'(t_a) + NW'({t_lam, 25'b0}) + NW'(sq_root);
    s7_mu_q  <= t_mu;
    s7_lam_q <= t_lam;
    s7_z_q   <= t_z;
  end

  // stage 8: acceptance test Z*2B <= (65536-Z)*N, and M*L
  logic            s8_v_q;
  logic [NW+16:0]  s8_rhs_q;
  logic [BW+16:0]  s8_lhs_q;
  logic [MuW+LamW-1:0] s8_ml_q;
  igvt_pkg::root_ctl_t s8_ctl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_v_q <= 1'b0;
    end else begin
      s8_v_q <= s7_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s8_rhs_q <= (NW+17)'(17'(17'h10000 - 17'(s7_z_q))) * (NW+17)'(s7_n_q);
    s8_lhs_q <= (BW+17)'({s7_z_q, 1'b0}) * (BW+17)'({s7_lam_q, 24'b0});
    s8_ml_q  <= (MuW+LamW)'(s7_mu_q) * (MuW+LamW)'(s7_lam_q);
    s8_ctl_q.small_root <= 1'b0;
    s8_ctl_q.mu  <= s7_mu_q;
    s8_ctl_q.lam <= s7_lam_q;
    s8_ctl_q.n   <= s7_n_q;
  end

  // stage 9: choose root, build numerator and divisor; M*N in two products
  logic            s9_v_q;
  logic [DNW-1:0]  s9_num_q;
  logic [DDW-1:0]  s9_den_q;
  logic            s9_small_q;
  logic            small_d;
  logic [DNW-1:0]  mn_lo, mn_hi;

  assign small_d = (NW+17)'(s8_lhs_q) <= s8_rhs_q;
  assign mn_lo   = DNW'(s8_ctl_q.mu) * DNW'(s8_ctl_q.n[28:0]);
  assign mn_hi   = DNW'(s8_ctl_q.mu) * DNW'(s8_ctl_q.n[NW-1:29]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s9_v_q <= 1'b0;
    end else begin
      s9_v_q <= s8_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s9_small_q <= small_d;
    if (small_d) begin
      s9_num_q <= DNW'({s8_ml_q, 25'b0});
      s9_den_q <= DDW'(s8_ctl_q.n);
    end else begin
      s9_num_q <= mn_lo + (mn_hi << 29);
      s9_den_q <= DDW'({s8_ctl_q.lam, 25'b0});
    end
  end

  logic          dv_v;
  logic [QW-1:0] dv_q;
  logic          dv_ovf;
  logic          dv_small;

  igvt_div #(.NumW(DNW), .DenW(DDW), .QW(QW), .TagW(1)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s9_v_q),
    .num_i   (s9_num_q),
    .den_i   (s9_den_q),
    .tag_i   (s9_small_q),
    .valid_o (dv_v),
    .quot_o  (dv_q),
    .ovf_o   (dv_ovf),
    .tag_o   (dv_small)
  );

  // output register: clamp the larger root
  logic                done_q;
  logic [QW-2:0]       var_q;
  logic                sat_q;
  logic                clamp;

  assign clamp = !dv_small && (dv_ovf || dv_q[QW-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    sat_q <= clamp;
    var_q <= clamp ? '1 : dv_q[QW-2:0];
  end

  assign done_o      = done_q;
  assign variate_o   = var_q;
  assign saturated_o = sat_q;

endmodule
`default_nettype wire
